// File: rtl/host_address_table_free_list_macros.svh
// assertion macros used by the checker file hatfl_checker.sv
`ifndef HOST_ADDRESS_TABLE_FREE_LIST_MACROS_SVH
`define HOST_ADDRESS_TABLE_FREE_LIST_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define HATFL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hatfl assertion failed");

// next-cycle implication
`define HATFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hatfl assertion failed");

`endif

// File: rtl/hatfl_pkg.sv
`timescale 1ns / 1ps

package hatfl_pkg;

  localparam int unsigned HOST_ADDR_W  = 32;
  localparam int unsigned ENTRY_IDX_W  = 11;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned IN_DATA_W    = 48;
  localparam int unsigned OUT_DATA_W   = 16;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_BADINDEX = 3'd4
  } status_e;

endpackage

// File: rtl/host_address_table_free_list.sv
// lookup: the table ram is scanned from entry 0 until a hit, one read per cycle; a miss
// scans the whole table, then allocates the free-list head or reports full; free or bad
// index needs no scan. one transaction in flight: a new item is taken only once the last
// result is in the result register. after reset a clearing pass zeroes the table, s_axis_tready held low
// the result register lets a new item enter while the previous result waits on m_axis_tready
`timescale 1ns / 1ps

module host_address_table_free_list #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] host_addr, [42:32] entry_index, [47:43] zero
  input  logic [hatfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] status, [12:3] slot, [15:13] zero
  output logic [hatfl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import hatfl_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned HW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = HW + HOST_ADDR_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [AW-1:0]          cmp_idx_q, cmp_idx_d;
  logic                   pend_q, pend_d;
  logic [HW-1:0]          head_q, head_d;
  logic                   out_valid_q;
  logic [OUT_DATA_W-1:0]  out_data_q;

  logic [HOST_ADDR_W-1:0] addr_q, addr_d;
  logic [ENTRY_IDX_W-1:0] idx_q, idx_d;
  status_e                res_status_q, res_status_d;
  logic [SLOT_W-1:0]      res_slot_q, res_slot_d;

  logic [EW-1:0]          mem_q [TABLE_DEPTH];
  logic [EW-1:0]          rdata_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [EW-1:0]          mem_wdata;
  logic [AW-1:0]          rd_addr;

  logic                   in_fire;
  logic                   out_free;
  logic                   hit;
  logic                   scan_done;
  logic [HW-1:0]          rd_link;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign hit       = pend_q && (rdata_q[HOST_ADDR_W-1:0] == addr_q);
  assign scan_done = (cnt_q == CW'(TABLE_DEPTH)) && !pend_q;
  assign rd_link   = rdata_q[EW-1:HOST_ADDR_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmp_idx_d    = cmp_idx_q;
    pend_d       = 1'b0;
    head_d       = head_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    mem_we       = 1'b0;
    mem_waddr    = cnt_q[AW-1:0];
    mem_wdata    = '0;
    rd_addr      = cnt_q[AW-1:0];

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          addr_d  = s_axis_tdata[HOST_ADDR_W-1:0];
          idx_d   = s_axis_tdata[HOST_ADDR_W+ENTRY_IDX_W-1:HOST_ADDR_W];
          cnt_d   = '0;
          state_d = s_axis_tuser ? S_FREE : S_SCAN;
        end
      end
      S_SCAN: begin
        // reads issue one per cycle, compare runs in the cycle after each read
        if (hit) begin
          res_status_d = ST_FOUND;
          res_slot_d   = SLOT_W'(cmp_idx_q);
          state_d      = S_RESP;
        end else if (scan_done) begin
          if (32'(head_q) >= 32'(TABLE_DEPTH)) begin
            res_status_d = ST_FULL;
            res_slot_d   = '0;
            state_d      = S_RESP;
          end else begin
            rd_addr = head_q[AW-1:0];
            state_d = S_ALLOC;
          end
        end else if (cnt_q != CW'(TABLE_DEPTH)) begin
          pend_d    = 1'b1;
          cmp_idx_d = cnt_q[AW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
      end
      S_ALLOC: begin
        // rdata_q holds the head entry here
        mem_we       = 1'b1;
        mem_waddr    = head_q[AW-1:0];
        mem_wdata    = {{HW{1'b0}}, addr_q};
        head_d       = (rd_link == '0) ? (head_q + 1'b1) : rd_link;
        res_status_d = ST_INSERTED;
        res_slot_d   = SLOT_W'(head_q);
        state_d      = S_RESP;
      end
      S_FREE: begin
        if (32'(idx_q) >= 32'(TABLE_DEPTH)) begin
          res_status_d = ST_BADINDEX;
          res_slot_d   = '0;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = AW'(idx_q);
          mem_wdata    = {head_q, {HOST_ADDR_W{1'b0}}};
          head_d       = HW'(idx_q);
          res_status_d = ST_FREED;
          res_slot_d   = SLOT_W'(idx_q);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      head_q  <= head_d;
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    idx_q        <= idx_d;
    cmp_idx_q    <= cmp_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    if (state_q == S_RESP && out_free) begin
      out_data_q <= OUT_DATA_W'({res_slot_q, res_status_q});
    end
  end

  // table ram: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

endmodule

// File: rtl/hatfl_checker.sv
`timescale 1ns / 1ps
`include "host_address_table_free_list_macros.svh"

module hatfl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [hatfl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [hatfl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import hatfl_pkg::*;

  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;

  assign out_status = m_axis_tdata[STATUS_W-1:0];
  assign out_slot   = m_axis_tdata[STATUS_W+SLOT_W-1:STATUS_W];

  // a held result stays put until taken
  `HATFL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  // one transaction in flight: input closes right after an accept
  `HATFL_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  `HATFL_ASSERT_SAME(a_status_legal, m_axis_tvalid, out_status <= STATUS_W'(ST_BADINDEX))

  // full and bad index carry no slot
  `HATFL_ASSERT_SAME(a_err_slot_zero,
    m_axis_tvalid && (out_status == STATUS_W'(ST_FULL) ||
                      out_status == STATUS_W'(ST_BADINDEX)),
    out_slot == '0)

endmodule

bind host_address_table_free_list hatfl_checker u_hatfl_checker (.*);
